// ===== rtl/core/mtmf_pkg.sv =====
// Shared types, constants and arithmetic helpers of the timed mute and fade engine.
package mtmf_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int CH_FIELD_W = 6;
  localparam int FADER_W = 17;
  localparam int LVL_W = 18;
  localparam int STEP_W = 16;
  localparam int PER_W = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W = 2 * STEP_W;
  localparam int INC_W = PROD_W - 8;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd2;

  localparam logic [STEP_W-1:0] STEP_SIZE_RST = 16'd768;
  localparam logic [PER_W-1:0] STEP_PERIOD_RST = 10'd20;
  localparam logic [STEP_W-1:0] ACCEL_RST = 16'd0;

  localparam logic signed [LVL_W-1:0] END_LEVEL = -18'sd22272;
  localparam logic signed [LVL_W-1:0] LEVEL_FLOOR = -18'sd65536;

  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_STARTED = 2'd0,
    ST_BUSY = 2'd1,
    ST_STEP = 2'd2,
    ST_DONE = 2'd3
  } status_t;

  typedef struct packed {
    logic action;
    logic [CH_FIELD_W-1:0] channel;
    logic mute_on;
    logic [FADER_W-1:0] fader_now;
  } item_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] out_channel;
    status_t status;
    logic fader_write;
    logic [FADER_W-1:0] fader_level;
    logic mute_write;
    logic mute_state;
    logic last;
  } result_t;

  typedef struct packed {
    logic load;
    logic ev_first;
    logic ev_second;
    logic commit;
    logic cnt_clr;
    logic cnt_inc;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic ev_act;
    logic busy;
    logic low;
    logic fade_cur;
    logic cnt_last;
    logic need_emit;
    logic can_emit;
    logic out_free;
    logic pend_v;
  } sts_t;

  // Lowers a level by a step and saturates at the floor.
  function automatic logic signed [LVL_W-1:0] lower(input logic signed [LVL_W-1:0] lvl,
                                                    input logic [STEP_W-1:0] step);
    logic signed [LVL_W:0] diff;
    logic signed [LVL_W:0] floor_ext;
    diff = {lvl[LVL_W-1], lvl} - $signed({{(LVL_W + 1 - STEP_W){1'b0}}, step});
    floor_ext = {LEVEL_FLOOR[LVL_W-1], LEVEL_FLOOR};
    if (diff < floor_ext) begin
      return LEVEL_FLOOR;
    end
    return diff[LVL_W-1:0];
  endfunction

  // Grows a step by the increment and saturates at the largest step.
  function automatic logic [STEP_W-1:0] grow(input logic [STEP_W-1:0] step,
                                             input logic [INC_W-1:0] inc);
    logic [INC_W:0] sum;
    sum = {{(INC_W + 1 - STEP_W){1'b0}}, step} + {1'b0, inc};
    if (|sum[INC_W:STEP_W]) begin
      return '1;
    end
    return sum[STEP_W-1:0];
  endfunction

endpackage

// ===== rtl/core/mtmf_if.sv =====
// Valid and ready channel interfaces for input items and result items.
interface mtmf_item_if;
  import mtmf_pkg::*;
  logic valid;
  logic ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtmf_result_if;
  import mtmf_pkg::*;
  logic valid;
  logic ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mtmf_ctrl.sv =====
// Controller state machine that sequences events, tick sweeps and result flushing.
module mtmf_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mtmf_pkg::sts_t sts,
  output mtmf_pkg::cmd_t cmd
);
  import mtmf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EVENT,
    S_EVENT2,
    S_SCAN,
    S_STEP,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.tick) begin
          cmd.cnt_clr = 1'b1;
          state_next = S_SCAN;
        end else if (sts.ev_act) begin
          state_next = S_EVENT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EVENT: begin
        if (sts.can_emit) begin
          cmd.ev_first = 1'b1;
          state_next = (!sts.busy && sts.low) ? S_EVENT2 : S_FLUSH;
        end
      end
      S_EVENT2: begin
        if (sts.can_emit) begin
          cmd.ev_second = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_SCAN: begin
        if (sts.fade_cur) begin
          state_next = S_STEP;
        end else if (sts.cnt_last) begin
          state_next = S_FLUSH;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_STEP: begin
        if (!sts.need_emit || sts.can_emit) begin
          cmd.commit = 1'b1;
          if (sts.cnt_last) begin
            state_next = S_FLUSH;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.pend_v) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// ===== rtl/core/mtmf_datapath.sv =====
// Datapath with configuration, channel state memory, fade arithmetic and result registers.
module mtmf_datapath #(
  parameter int NUM_CHANNELS = mtmf_pkg::MAX_CHANNELS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [mtmf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mtmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mtmf_pkg::item_t item_data,
  input  mtmf_pkg::cmd_t cmd,
  output mtmf_pkg::sts_t sts,
  output logic res_valid,
  input  logic res_ready,
  output mtmf_pkg::result_t res_data
);
  import mtmf_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CH_FIELD_W:0] CH_LIMIT = (CH_FIELD_W + 1)'(NUM_CHANNELS);

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [STEP_W-1:0] step;
    logic [FADER_W-1:0] rest;
    logic [PER_W-1:0] per;
  } mem_word_t;

  logic [STEP_W-1:0] step_size;
  logic [PER_W-1:0] step_period;
  logic [STEP_W-1:0] accel;
  logic [INC_W-1:0] inc;
  logic [PROD_W-1:0] prod;

  item_t it_q;
  logic [NUM_CHANNELS-1:0] fading;
  mem_word_t mem [NUM_CHANNELS];
  mem_word_t rd_q;
  logic [CH_W-1:0] cnt;

  logic [CH_W-1:0] ev_idx;
  logic ch_ok;
  logic signed [LVL_W-1:0] now_ext;
  logic busy;
  logic low;

  logic [PER_W-1:0] per_eff;
  logic [PER_W-1:0] per_n;
  logic due;
  logic live;

  logic signed [LVL_W-1:0] lo_lvl;
  logic [STEP_W-1:0] lo_step;
  logic signed [LVL_W-1:0] lvl_new;
  logic [STEP_W-1:0] step_new;

  logic mem_we;
  logic [CH_W-1:0] mem_addr;
  mem_word_t mem_wd;

  logic emit;
  result_t new_res;
  result_t pend;
  result_t flush_res;
  logic pend_v;
  logic out_free;
  logic can_emit;

  assign prod = step_size * accel;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_SIZE_RST;
      step_period <= STEP_PERIOD_RST;
      accel <= ACCEL_RST;
      inc <= '0;
    end else begin
      inc <= prod[PROD_W-1:8];
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_STEP_SIZE: step_size <= cfg_data;
          REG_STEP_PERIOD: step_period <= cfg_data[PER_W-1:0];
          REG_ACCEL: accel <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_q <= item_data;
    end
  end

  assign ev_idx = it_q.channel[CH_W-1:0];
  assign ch_ok = ({1'b0, it_q.channel} < CH_LIMIT);
  assign now_ext = {it_q.fader_now[FADER_W-1], it_q.fader_now};
  assign busy = fading[ev_idx];
  assign low = (now_ext <= END_LEVEL);

  assign per_eff = (step_period == '0) ? PER_W'(1) : step_period;
  assign per_n = rd_q.per + PER_W'(1);
  assign due = (per_n >= per_eff);
  assign live = ($signed(rd_q.lvl) > END_LEVEL);

  assign lo_lvl = cmd.commit ? $signed(rd_q.lvl) : now_ext;
  assign lo_step = cmd.commit ? rd_q.step : step_size;
  assign lvl_new = lower(lo_lvl, lo_step);
  assign step_new = grow(lo_step, inc);

  always_comb begin
    mem_we = 1'b0;
    mem_addr = cnt;
    mem_wd = rd_q;
    if (cmd.ev_first && !busy && !low) begin
      mem_we = 1'b1;
      mem_addr = ev_idx;
      mem_wd.lvl = lvl_new;
      mem_wd.step = step_new;
      mem_wd.rest = it_q.fader_now;
      mem_wd.per = '0;
    end else if (cmd.commit) begin
      mem_we = 1'b1;
      if (!due) begin
        mem_wd.per = per_n;
      end else if (live) begin
        mem_wd.lvl = lvl_new;
        mem_wd.step = step_new;
        mem_wd.per = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_q <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fading <= '0;
      cnt <= '0;
    end else begin
      if (cmd.ev_first && !busy && !low) begin
        fading[ev_idx] <= 1'b1;
      end else if (cmd.commit && due && !live) begin
        fading[cnt] <= 1'b0;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CH_W'(1);
      end
    end
  end

  always_comb begin
    new_res = '0;
    emit = 1'b0;
    if (cmd.ev_first) begin
      emit = 1'b1;
      new_res.out_channel = it_q.channel;
      new_res.mute_write = 1'b1;
      if (busy) begin
        new_res.status = ST_BUSY;
      end else begin
        new_res.status = ST_STARTED;
        if (!low) begin
          new_res.fader_write = 1'b1;
          new_res.fader_level = lvl_new[FADER_W-1:0];
        end
      end
    end else if (cmd.ev_second) begin
      emit = 1'b1;
      new_res.out_channel = it_q.channel;
      new_res.status = ST_DONE;
      new_res.fader_write = 1'b1;
      new_res.fader_level = it_q.fader_now;
      new_res.mute_write = 1'b1;
      new_res.mute_state = 1'b1;
    end else if (cmd.commit && due) begin
      emit = 1'b1;
      new_res.out_channel = CH_FIELD_W'(cnt);
      new_res.fader_write = 1'b1;
      if (live) begin
        new_res.status = ST_STEP;
        new_res.fader_level = lvl_new[FADER_W-1:0];
      end else begin
        new_res.status = ST_DONE;
        new_res.fader_level = rd_q.rest;
        new_res.mute_write = 1'b1;
        new_res.mute_state = 1'b1;
      end
    end
  end

  assign out_free = !res_valid || res_ready;
  assign can_emit = !pend_v || out_free;

  always_comb begin
    flush_res = pend;
    flush_res.last = 1'b1;
  end

  // The newest result waits in a hold register until it is known whether another follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        pend <= new_res;
        pend_v <= 1'b1;
      end else if (cmd.flush && pend_v) begin
        pend_v <= 1'b0;
      end
      if (emit && pend_v) begin
        res_data <= pend;
        res_valid <= 1'b1;
      end else if (!emit && cmd.flush && pend_v) begin
        res_data <= flush_res;
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.tick = (it_q.action == ACT_TICK);
    sts.ev_act = it_q.mute_on && ch_ok;
    sts.busy = busy;
    sts.low = low;
    sts.fade_cur = fading[cnt];
    sts.cnt_last = (cnt == LAST_IDX);
    sts.need_emit = due;
    sts.can_emit = can_emit;
    sts.out_free = out_free;
    sts.pend_v = pend_v;
  end

endmodule

// ===== rtl/core/multichannel_timed_mute_fade.sv =====
// Top level of the per-channel timed mute and fade-down engine.
// A mute event gives one result, or two when an idle channel is already at or below
// the end level. A tick sweeps the channel state memory channel by channel, with a
// step state for each fading channel; one transaction is worked on at a time.
// Synchronous reset clears the fade flags, configuration and handshake state; the state memory
// holds no reset value and is always written before it is read.
module multichannel_timed_mute_fade #(
  parameter int NUM_CHANNELS = mtmf_pkg::MAX_CHANNELS
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [mtmf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input logic [mtmf_pkg::CFG_DATA_W-1:0] cfg_data,
  mtmf_item_if.sink events,
  mtmf_result_if.source results
);
  import mtmf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mtmf_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(events.valid),
    .in_ready(events.ready),
    .sts(sts),
    .cmd(cmd)
  );

  mtmf_datapath #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .item_data(events.data),
    .cmd(cmd),
    .sts(sts),
    .res_valid(results.valid),
    .res_ready(results.ready),
    .res_data(results.data)
  );

endmodule

// ===== rtl/core/mtmf_checker.sv =====
// Port-level assertions for the timed mute and fade engine and their bind to the top level.
module mtmf_checker (
  input logic clk,
  input logic rst,
  input logic ev_valid,
  input logic ev_ready,
  input logic res_valid,
  input logic res_ready,
  input mtmf_pkg::result_t res_data
);
  import mtmf_pkg::*;

  // A stalled result transaction keeps its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // Only one input transaction is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_ready |=> !ev_ready)
    else $error("input accepted while busy");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A busy report is always alone and only unmutes.
  a_busy_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == ST_BUSY |->
      res_data.last && res_data.mute_write && !res_data.mute_state && !res_data.fader_write)
    else $error("malformed busy result");

  // A finished fade mutes and restores; a ramp step only writes the fader.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      (res_data.status != ST_DONE ||
       (res_data.fader_write && res_data.mute_write && res_data.mute_state)) &&
      (res_data.status != ST_STEP || (res_data.fader_write && !res_data.mute_write)) &&
      (res_data.fader_write || res_data.fader_level == '0))
    else $error("result fields inconsistent with status");

endmodule

bind multichannel_timed_mute_fade mtmf_checker u_checker (
  .clk(clk),
  .rst(rst),
  .ev_valid(events.valid),
  .ev_ready(events.ready),
  .res_valid(results.valid),
  .res_ready(results.ready),
  .res_data(results.data)
);

// ===== bench/multichannel_timed_mute_fade_test.sv =====
// Self-checking testbench for the per-channel timed mute and fade-down engine.
`timescale 1ns / 1ps

module multichannel_timed_mute_fade_test;
  import mtmf_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT = 100;

  typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    int reg_val;
    item_t it;
    int reps;
    int n_typed;
    result_t typed_a;
    result_t typed_b;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mtmf_item_if item_ch();
  mtmf_result_if result_ch();

  multichannel_timed_mute_fade uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .events(item_ch),
    .results(result_ch)
  );

  always #6 clk = ~clk;

  // Fade engine shadow state and configuration.
  logic [15:0] cfg_step_size;
  logic [9:0] cfg_period;
  logic [15:0] cfg_accel;
  logic fading [MAX_CHANNELS];
  logic signed [17:0] cur_level [MAX_CHANNELS];
  logic [15:0] cur_step [MAX_CHANNELS];
  logic signed [16:0] restore_lvl [MAX_CHANNELS];
  logic [9:0] per_cnt [MAX_CHANNELS];

  result_t fresh[$];
  result_t owed[$];
  plan_row_t plan[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  function automatic logic signed [17:0] drop_level(input logic signed [17:0] lvl,
                                                    input logic [15:0] step);
    int v;
    v = int'(lvl) - int'(step);
    if (v < int'(LEVEL_FLOOR)) v = int'(LEVEL_FLOOR);
    return v[17:0];
  endfunction

  function automatic logic [15:0] raise_step(input logic [15:0] step);
    longint s;
    s = longint'(step) + ((longint'(cfg_step_size) * longint'(cfg_accel)) >> 8);
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic result_t fade_result(input int ch, input status_t st, input bit fw,
                                          input int lvl, input bit mw, input bit ms,
                                          input bit lst);
    result_t r;
    r.out_channel = ch[5:0];
    r.status = st;
    r.fader_write = fw;
    r.fader_level = fw ? lvl[16:0] : '0;
    r.mute_write = mw;
    r.mute_state = mw & ms;
    r.last = lst;
    return r;
  endfunction

  // Works out the results of one accepted transaction and updates the shadow state.
  function automatic void forecast_fade(input item_t it);
    logic signed [16:0] now;
    logic [9:0] per;
    int ch;
    fresh.delete();
    now = $signed(it.fader_now);
    ch = it.channel;
    if (it.action == ACT_EVENT) begin
      if (it.mute_on) begin
        if (fading[ch]) begin
          fresh.push_back(fade_result(ch, ST_BUSY, 1'b0, 0, 1'b1, 1'b0, 1'b0));
        end else if (now <= END_LEVEL) begin
          fresh.push_back(fade_result(ch, ST_STARTED, 1'b0, 0, 1'b1, 1'b0, 1'b0));
          fresh.push_back(fade_result(ch, ST_DONE, 1'b1, now, 1'b1, 1'b1, 1'b0));
        end else begin
          restore_lvl[ch] = now;
          cur_level[ch] = drop_level(now, cfg_step_size);
          cur_step[ch] = raise_step(cfg_step_size);
          per_cnt[ch] = '0;
          fading[ch] = 1'b1;
          fresh.push_back(fade_result(ch, ST_STARTED, 1'b1, cur_level[ch], 1'b1, 1'b0, 1'b0));
        end
      end
    end else begin
      per = (cfg_period == '0) ? 10'd1 : cfg_period;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        if (fading[c]) begin
          per_cnt[c] = per_cnt[c] + 10'd1;
          if (per_cnt[c] >= per) begin
            per_cnt[c] = '0;
            if (cur_level[c] > END_LEVEL) begin
              cur_level[c] = drop_level(cur_level[c], cur_step[c]);
              cur_step[c] = raise_step(cur_step[c]);
              fresh.push_back(fade_result(c, ST_STEP, 1'b1, cur_level[c], 1'b0, 1'b0, 1'b0));
            end else begin
              fading[c] = 1'b0;
              fresh.push_back(fade_result(c, ST_DONE, 1'b1, restore_lvl[c], 1'b1, 1'b1,
                                          1'b0));
            end
          end
        end
      end
    end
    if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
  endfunction

  function automatic item_t mute_event(input int ch, input bit on, input int lvl);
    item_t it;
    it.action = ACT_EVENT;
    it.channel = ch[5:0];
    it.mute_on = on;
    it.fader_now = lvl[16:0];
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int lvl;
    it.action = ($urandom_range(0, 99) < 45) ? ACT_TICK : ACT_EVENT;
    it.channel = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 7));
    it.mute_on = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 9)) inside
      0: lvl = -36864;
      1: lvl = 2560;
      [2:3]: lvl = -int'($urandom_range(22272, 36864));
      default: lvl = int'($urandom_range(0, 22560)) - 20000;
    endcase
    it.fader_now = lvl[16:0];
    return it;
  endfunction

  function automatic item_t tick_item();
    item_t it;
    it = random_item();
    it.action = ACT_TICK;
    return it;
  endfunction

  function automatic void plan_item(input item_t it, input int reps, input int n_typed = -1,
                                    input result_t a = '0, input result_t b = '0);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.reg_idx = '0;
    r.reg_val = 0;
    r.it = it;
    r.reps = reps;
    r.n_typed = n_typed;
    r.typed_a = a;
    r.typed_b = b;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t r;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.it = '0;
    r.reps = 0;
    r.n_typed = 0;
    r.typed_a = '0;
    r.typed_b = '0;
    plan.push_back(r);
  endfunction

  task automatic offer(input item_t it, input bit use_forecast = 1'b1);
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    do @(posedge clk); while (!item_ch.ready);
    forecast_fade(it);
    if (use_forecast) foreach (fresh[k]) owed.push_back(fresh[k]);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Registers change only once the engine has drained and finished any silent tick.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    item_ch.valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STEP_SIZE: cfg_step_size = val[15:0];
      REG_STEP_PERIOD: cfg_period = val[9:0];
      REG_ACCEL: cfg_accel = val[15:0];
      default: ;
    endcase
  endtask

  function automatic void match(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (owed.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: expected no result, got channel %0d status %0d", $time,
                   result_ch.data.out_channel, result_ch.data.status);
      end else begin
        want = owed.pop_front();
        match("out_channel", want.out_channel, result_ch.data.out_channel);
        match("status", want.status, result_ch.data.status);
        match("fader_write", want.fader_write, result_ch.data.fader_write);
        match("fader_level", $signed(want.fader_level), $signed(result_ch.data.fader_level));
        match("mute_write", want.mute_write, result_ch.data.mute_write);
        match("mute_state", want.mute_state, result_ch.data.mute_state);
        match("last", want.last, result_ch.data.last);
      end
    end
  end

  initial begin
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL multichannel_timed_mute_fade");
    $finish;
  end

  initial begin
    int sz;
    int per;
    int acc;
    int count;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    cfg_step_size = 16'd768;
    cfg_period = 10'd20;
    cfg_accel = 16'd0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      fading[c] = 1'b0;
      per_cnt[c] = '0;
    end

    plan_item(mute_event(0, 1'b1, 0), 1, 1,
              fade_result(0, ST_STARTED, 1'b1, -768, 1'b1, 1'b0, 1'b1));
    plan_item(mute_event(0, 1'b1, 2560), 1, 1,
              fade_result(0, ST_BUSY, 1'b0, 0, 1'b1, 1'b0, 1'b1));
    plan_item(mute_event(63, 1'b0, -1), 1, 0);
    plan_item(mute_event(63, 1'b1, -36864), 1, 2,
              fade_result(63, ST_STARTED, 1'b0, 0, 1'b1, 1'b0, 1'b0),
              fade_result(63, ST_DONE, 1'b1, -36864, 1'b1, 1'b1, 1'b1));
    plan_item(mute_event(5, 1'b1, -22272), 1, 2,
              fade_result(5, ST_STARTED, 1'b0, 0, 1'b1, 1'b0, 1'b0),
              fade_result(5, ST_DONE, 1'b1, -22272, 1'b1, 1'b1, 1'b1));
    plan_item(mute_event(6, 1'b1, -22271), 1, 1,
              fade_result(6, ST_STARTED, 1'b1, -23039, 1'b1, 1'b0, 1'b1));
    plan_item(tick_item(), 20);
    plan_reg(REG_STEP_SIZE, 65535);
    plan_reg(REG_STEP_PERIOD, 0);
    plan_reg(REG_ACCEL, 65535);
    plan_item(mute_event(1, 1'b1, -22271), 1, 1,
              fade_result(1, ST_STARTED, 1'b1, -65536, 1'b1, 1'b0, 1'b1));
    plan_item(tick_item(), 2);
    plan_reg(REG_STEP_SIZE, 0);
    plan_reg(REG_ACCEL, 0);
    plan_reg(REG_STEP_PERIOD, 1);
    plan_item(mute_event(2, 1'b1, -1), 1, 1,
              fade_result(2, ST_STARTED, 1'b1, -1, 1'b1, 1'b0, 1'b1));
    plan_item(tick_item(), 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        repeat (plan[r].reps) begin
          offer(plan[r].it, plan[r].n_typed < 0);
          if (plan[r].n_typed > 0) owed.push_back(plan[r].typed_a);
          if (plan[r].n_typed > 1) owed.push_back(plan[r].typed_b);
          maybe_idle();
        end
      end
    end

    for (int p = 0; p < 6; p++) begin
      count = 35;
      case (p)
        0: begin sz = 768; per = 1; acc = 0; end
        1: begin sz = 2048; per = 2; acc = 64; end
        2: begin
          sz = $urandom_range(256, 4096);
          per = $urandom_range(1, 3);
          acc = $urandom_range(0, 512);
        end
        3: begin sz = 1; per = 1; acc = 65535; count = 30; end
        4: begin sz = 65535; per = 12; acc = 0; end
        default: begin sz = 512; per = 3; acc = 300; end
      endcase
      write_reg(REG_STEP_SIZE, sz);
      write_reg(REG_STEP_PERIOD, per);
      write_reg(REG_ACCEL, acc);
      calm = (p == 5);
      if (p == 4) begin
        offer(mute_event(10, 1'b1, 2560));
        repeat (30) offer(tick_item());
      end else begin
        for (int i = 0; i < count; i++) begin
          if (p == 1 && i == 10) hold_req = 1'b1;
          if (p == 1 && i == 30) begin
            item_ch.valid <= 1'b0;
            do @(posedge clk); while (owed.size() != 0);
          end
          offer(random_item());
          maybe_idle();
        end
      end
    end

    item_ch.valid <= 1'b0;
    do @(posedge clk); while (owed.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && owed.size() == 0) begin
      $display("PASS multichannel_timed_mute_fade");
    end else begin
      $display("FAIL multichannel_timed_mute_fade");
    end
    $finish;
  end

endmodule
